// File: design/dip_pkg.sv
// Package for the dotted IPv4 text parser: phase and radix codes, part masks,
// and the input stage to core handoff struct. No dependencies.
package dip_pkg;

  // Parse phase of the current part
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_DONE   = 3'd3,
    PH_FAIL   = 3'd4
  } phase_t;

  // Number base of the current part
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  localparam int unsigned MAX_PARTS = 4;

  // Masks for the last part of an 8.24, 8.8.16 or 8.8.8.8 address
  localparam logic [31:0] MASK_24 = 32'h00ff_ffff;
  localparam logic [31:0] MASK_16 = 32'h0000_ffff;
  localparam logic [31:0] MASK_8  = 32'h0000_00ff;

  localparam logic [31:0] ADDR_ERROR = 32'hffff_ffff;

  // Character held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] text_char;
    logic       last_char;
  } dip_stage_t;

endpackage

// File: design/dip_in_if.sv
// Character channel: valid/ready handshake carrying one text character.
// Depends on nothing.
interface dip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// File: design/dip_out_if.sv
// Result channel: valid/ready handshake carrying one parsed address.
// Depends on nothing.
interface dip_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        error;

  modport source (output valid, output address, output error, input ready);
  modport sink   (input valid, input address, input error, output ready);
endinterface

// File: design/dip_in_reg.sv
// Input register of the parser: captures one character per transfer.
// Depends on dip_pkg and dip_in_if.
module dip_in_reg
  import dip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dip_in_if.sink     chars,
  input  logic       advance,
  output dip_stage_t stage
);

  // Take a new character when empty or when the held one moves on
  assign chars.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (chars.ready) begin
      stage.valid <= chars.valid;
    end
    if (chars.ready) begin
      stage.text_char <= chars.text_char;
      stage.last_char <= chars.last_char;
    end
  end

endmodule

// File: design/dip_core.sv
// Parse state update and result register of the parser.
// Depends on dip_pkg and dip_out_if.
module dip_core
  import dip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dip_stage_t stage,
  output logic       advance,
  dip_out_if.source  results
);

  phase_t      phase, phase_next;
  radix_t      radix, radix_next;
  logic [31:0] part_value, part_value_next;
  logic [2:0]  part_count, part_count_next;
  // Only the low byte of the first three parts ever reaches the address
  logic [7:0]  parts [3];
  logic [7:0]  parts_next [3];

  logic [31:0] address_next;
  logic        error_next;
  logic        load;

  logic [7:0]  c;
  logic [3:0]  digit;
  logic        is_blank, is_dec, is_lower, is_upper;

  assign c = stage.text_char;

  // A character moves on unless it ends a string and the result slot is full
  assign advance = stage.valid && (!stage.last_char || !results.valid || results.ready);
  assign load    = advance && stage.last_char;

  // Character classes
  always_comb begin
    is_blank = (c == 8'h00) || (c == 8'h20) || (c inside {[8'h09:8'h0d]});
    is_dec   = c inside {["0":"9"]};
    is_lower = c inside {["a":"f"]};
    is_upper = c inside {["A":"F"]};
    if (is_lower) begin
      digit = 4'(c - 8'h57);
    end else if (is_upper) begin
      digit = 4'(c - 8'h37);
    end else begin
      digit = 4'(c - 8'h30);
    end
  end

  // Next parse state for one character
  always_comb begin
    phase_next      = phase;
    radix_next      = radix;
    part_value_next = part_value;
    part_count_next = part_count;
    parts_next      = parts;
    if (phase != PH_DONE && phase != PH_FAIL) begin
      if (is_blank) begin
        phase_next = PH_DONE;
      end else if (phase == PH_START && c == "0") begin
        radix_next = RADIX_OCT;
        phase_next = PH_ZERO;
      end else if ((phase == PH_START || phase == PH_ZERO) && (c == "x" || c == "X")) begin
        radix_next = RADIX_HEX;
        phase_next = PH_DIGITS;
      end else if (c == ".") begin
        if (part_count >= 3'(MAX_PARTS)) begin
          phase_next = PH_FAIL;
        end else begin
          // A fourth stored part is never packed, so it needs no storage
          if (part_count < 3'(MAX_PARTS - 1)) begin
            parts_next[part_count[1:0]] = part_value[7:0];
          end
          part_count_next = part_count + 3'd1;
          part_value_next = '0;
          radix_next      = RADIX_DEC;
          phase_next      = PH_START;
        end
      end else if (is_dec || (radix == RADIX_HEX && (is_lower || is_upper))) begin
        case (radix)
          RADIX_HEX: part_value_next = {part_value[27:0], 4'b0} + 32'(digit);
          RADIX_OCT: part_value_next = {part_value[28:0], 3'b0} + 32'(digit);
          default:   part_value_next = {part_value[28:0], 3'b0}
                                     + {part_value[30:0], 1'b0} + 32'(digit);
        endcase
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_FAIL;
      end
    end
  end

  // Pack the parts; the current part value is the final part
  always_comb begin
    error_next = (phase_next == PH_FAIL) || (part_count_next >= 3'(MAX_PARTS));
    case (part_count_next)
      3'd0:    address_next = part_value_next;
      3'd1:    address_next = {parts_next[0], 24'b0} | (part_value_next & MASK_24);
      3'd2:    address_next = {parts_next[0], parts_next[1], 16'b0}
                            | (part_value_next & MASK_16);
      3'd3:    address_next = {parts_next[0], parts_next[1], parts_next[2], 8'b0}
                            | (part_value_next & MASK_8);
      default: address_next = ADDR_ERROR;
    endcase
    if (error_next) begin
      address_next = ADDR_ERROR;
    end
  end

  // Parse state registers; cleared after each string
  always_ff @(posedge clk) begin
    if (rst || load) begin
      phase      <= PH_START;
      radix      <= RADIX_DEC;
      part_value <= '0;
      part_count <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      radix      <= radix_next;
      part_value <= part_value_next;
      part_count <= part_count_next;
    end
    if (advance) begin
      parts <= parts_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (load) begin
      results.address <= address_next;
      results.error   <= error_next;
    end
  end

endmodule

// File: design/dotted_ipv4_text_parser_top.sv
// Top level of the dotted IPv4 text parser: input register plus parse core.
// Depends on dip_pkg, dip_in_if, dip_out_if, dip_in_reg and dip_core.
//
// Feed the address text one character per transfer on chars, with last_char
// set on the final character; one result (address, error) follows for each
// string. The block takes one character every cycle unless a final character
// waits on a full result register. Each character passes the input register
// and one short update of the parse state (a shift-add into the part value)
// before the result register. NUL or whitespace ends the text early; on any
// error the address is all ones and error is set.
module dotted_ipv4_text_parser_top
  import dip_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  dip_in_if.sink    chars,
  dip_out_if.source results
);

  dip_stage_t stage;
  logic       advance;

  dip_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .stage   (stage)
  );

  dip_core u_core (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .results (results)
  );

endmodule

// File: design/dip_checker.sv
// Port-level checks for the dotted IPv4 text parser, bound to the top level.
// Depends on dotted_ipv4_text_parser_top.
module dip_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_address,
  input logic        out_error
);

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_address) && $stable(out_error))
    else $error("stalled result changed");

  // An error result carries the all-ones address
  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_address == 32'hffff_ffff)
    else $error("error result without all-ones address");

  // A fresh result follows the transfer of a final character through the input and result registers
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a final character");

  // A free result side never stalls the character side
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

endmodule

bind dotted_ipv4_text_parser_top dip_checker u_dip_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .in_last     (chars.last_char),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_address (results.address),
  .out_error   (results.error)
);
